// ===== hw/rtl/ssearch_pkg.sv =====
package ssearch_pkg;

    // item kinds carried on s_tuser
    localparam logic [1:0] FUNC_PATTERN = 2'd0;
    localparam logic [1:0] FUNC_TEXT    = 2'd1;
    localparam logic [1:0] FUNC_END     = 2'd2;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic pat_shift;
        logic txt_shift;
        logic clear;
        logic fold_en;
    } ssearch_ctl_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ic);
        logic [7:0] r;
        r = c;
        if (ic && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z))
        begin
            r = 8'(c - CHAR_UPPER_A + CHAR_LOWER_A);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ssearch_cell.sv =====
// One window position: pattern byte, text byte, occupancy bits and a compare.
module ssearch_cell
    import ssearch_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ssearch_ctl_t ctl,
    input  logic [7:0]   pat_in,
    input  logic [7:0]   text_in,
    input  logic         act_in,
    input  logic         tv_in,
    output logic [7:0]   pat_out,
    output logic [7:0]   text_out,
    output logic         act_out,
    output logic         tv_out,
    output logic         hit
);

    logic [7:0] pat_reg;
    logic [7:0] text_reg;
    logic       act_reg;   // cell holds a pattern byte
    logic       tv_reg;    // cell holds a text byte
    logic       hit_reg;
    logic       hit_next;

    // compare against the byte about to shift in
    always_comb
    begin
        hit_next = !act_reg ||
                   (tv_in && (fold_byte(text_in, ctl.fold_en) ==
                              fold_byte(pat_reg, ctl.fold_en)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            tv_reg  <= 1'b0;
        end
        else if (ctl.clear)
        begin
            act_reg <= 1'b0;
            tv_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.pat_shift)
            begin
                act_reg <= act_in;
            end
            if (ctl.txt_shift)
            begin
                tv_reg <= tv_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pat_shift)
        begin
            pat_reg <= pat_in;
        end
        if (ctl.txt_shift)
        begin
            text_reg <= text_in;
            hit_reg  <= hit_next;
        end
    end

    assign pat_out  = pat_reg;
    assign text_out = text_reg;
    assign act_out  = act_reg;
    assign tv_out   = tv_reg;
    assign hit      = hit_reg;

endmodule

// ===== hw/rtl/substring_search_case_fold_core.sv =====
// Channel   Dir  Word fields (low bit up)                     Notes
// s_*       in   tdata: char_byte[7:0]; tuser: func[1:0]      0 pattern, 1 text, 2 end
// m_*       out  tdata: found[0], pattern_too_long[1], 0[7:2] one word per end item
// cfg_*     in   cfg_data: fold_en[0]                         always ready
//
// One word per cycle sustained while results are taken. Pattern and text
// bytes shift through a row of PAT_MAX cells; each cell registers its compare,
// the hit bits are ANDed the cycle after and folded into a sticky match flag.
// An end word loads the result register directly; results show the next cycle.
// s_tready drops only while a result waits and m_tready is low.
// Reset (rst_n, async, low) clears the search state and the fold enable.
module substring_search_case_fold_core
    import ssearch_pkg::*;
#(
    parameter int PAT_MAX = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic [1:0] s_tuser,   // [1:0] func
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] found, [1] pattern_too_long, [7:2] zero
    // config write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [0:0] cfg_data   // [0] fold_en
);

    localparam int PLEN_W = $clog2(PAT_MAX + 1);

    logic              fold_en_reg;
    logic [PLEN_W-1:0] plen_reg;
    logic [PLEN_W-1:0] plen_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              match_reg;
    logic              match_next;
    logic              txt_p_reg;     // hit bits hold a fresh text compare
    logic              txt_p_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              found_reg;
    logic              too_long_reg;

    logic              acc;
    logic              pat_full;
    logic              all_hit;
    logic              cur_match;
    ssearch_ctl_t      ctl;

    logic [7:0]        pat_link  [PAT_MAX];
    logic [7:0]        text_link [PAT_MAX];
    logic              act_link  [PAT_MAX];
    logic              tv_link   [PAT_MAX];
    logic [PAT_MAX-1:0] hit_vec;

    assign s_tready  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign acc       = s_tvalid && s_tready;
    assign pat_full  = (plen_reg == PLEN_W'(PAT_MAX));

    always_comb
    begin
        ctl.pat_shift = acc && (s_tuser == FUNC_PATTERN) && !pat_full;
        ctl.txt_shift = acc && (s_tuser == FUNC_TEXT);
        ctl.clear     = acc && (s_tuser == FUNC_END);
        ctl.fold_en   = fold_en_reg;
    end

    // row of cells; the newest byte enters at cell 0
    for (genvar k = 0; k < PAT_MAX; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            ssearch_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .pat_in   (s_tdata),
                .text_in  (s_tdata),
                .act_in   (1'b1),
                .tv_in    (1'b1),
                .pat_out  (pat_link[k]),
                .text_out (text_link[k]),
                .act_out  (act_link[k]),
                .tv_out   (tv_link[k]),
                .hit      (hit_vec[k])
            );
        end
        else
        begin : g_body
            ssearch_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .pat_in   (pat_link[k-1]),
                .text_in  (text_link[k-1]),
                .act_in   (act_link[k-1]),
                .tv_in    (tv_link[k-1]),
                .pat_out  (pat_link[k]),
                .text_out (text_link[k]),
                .act_out  (act_link[k]),
                .tv_out   (tv_link[k]),
                .hit      (hit_vec[k])
            );
        end
    end

    assign all_hit   = &hit_vec;
    assign cur_match = match_reg || (txt_p_reg && all_hit);

    always_comb
    begin
        plen_next    = plen_reg;
        ovf_next     = ovf_reg;
        match_next   = cur_match;
        txt_p_next   = ctl.txt_shift && (plen_reg != '0);
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (acc && (s_tuser == FUNC_PATTERN))
        begin
            if (pat_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                plen_next = plen_reg + 1'b1;
            end
        end
        if (ctl.clear)
        begin
            plen_next    = '0;
            ovf_next     = 1'b0;
            match_next   = 1'b0;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_en_reg <= 1'b0;
            plen_reg    <= '0;
            ovf_reg     <= 1'b0;
            match_reg   <= 1'b0;
            txt_p_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                fold_en_reg <= cfg_data[0];
            end
            plen_reg    <= plen_next;
            ovf_reg     <= ovf_next;
            match_reg   <= match_next;
            txt_p_reg   <= txt_p_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result word, loaded on the end item
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            found_reg    <= cur_match || (plen_reg == '0);
            too_long_reg <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, too_long_reg, found_reg};

endmodule

// ===== hw/rtl/ssearch_chk.sv =====
module ssearch_chk
    import ssearch_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // stalled result stays up
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // an accepted end word gives a result next cycle
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == FUNC_END) |=> m_tvalid)
        else $error("end word produced no result");

    // results only follow end words
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == FUNC_END)))
        else $error("result without end word");

    // padding bits of the result word stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:2] == 6'b0))
        else $error("result padding nonzero");

endmodule

bind substring_search_case_fold_core ssearch_chk u_ssearch_chk (.*);

// ===== bench/tb.sv =====
// Testbench for substring_search_case_fold_core.
// Words go in on the s_* stream (tuser = kind, tdata = byte). Reports come back on m_*.
// A scoreboard object tracks the pattern, the text window and the flags, and queues one
// expected report for every accepted end word. Each report is checked against the oldest
// expected report.
module tb
    import ssearch_pkg::*;
;

    localparam int PAT_MAX        = 16;
    localparam int RANDOM_WORDS   = 1720;    // spread over four idling phases
    localparam int DRAIN_CYCLES   = 8;       // compare stage + hit stage + report register
    localparam int HOLD_CYCLES    = 300;     // long receiver hold-off, fills the block
    localparam int WATCHDOG_LIMIT = 3000;    // cycles with no handshake at all

    // kind code the block has to ignore
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [7:0] CASE_GAP     = CHAR_LOWER_A - CHAR_UPPER_A;
    localparam logic [7:0] CHAR_LOWER_Z = CHAR_LOWER_A + (CHAR_UPPER_Z - CHAR_UPPER_A);

    typedef struct {
        bit found;
        bit too_long;
    } report_t;

    typedef struct packed {
        logic [1:0] fn;
        logic [7:0] ch;
    } word_t;

    // Tracks the search state and holds the reports the block still owes.
    class search_scoreboard;
        logic [7:0] pat_mem [PAT_MAX];
        logic [7:0] txt_win [PAT_MAX];  // [0] newest text byte
        int pat_len;
        int text_cnt;                   // saturates at PAT_MAX
        bit hit;
        bit overflow;
        bit fold_on;
        report_t report_q[$];
        int unsigned errors = 0;
        int unsigned words = 0;
        int unsigned reports = 0;
        int unsigned found_cnt = 0;
        int unsigned overflow_cnt = 0;
        int unsigned fold_writes[2] = '{0, 0};

        function new();
            fold_on = 1'b0;
            clear();
        endfunction

        function void clear();
            pat_len = 0;
            text_cnt = 0;
            hit = 1'b0;
            overflow = 1'b0;
            foreach (txt_win[k])
                txt_win[k] = '0;
        endfunction

        function logic [7:0] folded(logic [7:0] c);
            if (fold_on && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
                return c + CASE_GAP;
            return c;
        endfunction

        function void set_fold(bit v);
            fold_on = v;
            fold_writes[v]++;
        endfunction

        function int pending();
            return report_q.size();
        endfunction

        function void note_word(logic [1:0] fn, logic [7:0] c);
            report_t r;
            bit same;
            int k;
            words++;
            case (fn)
                FUNC_PATTERN:
                begin
                    if (pat_len < PAT_MAX)
                    begin
                        pat_mem[pat_len] = c;
                        pat_len++;
                    end
                    else
                        overflow = 1'b1;
                end
                FUNC_TEXT:
                begin
                    for (k = PAT_MAX - 1; k > 0; k--)
                        txt_win[k] = txt_win[k - 1];
                    txt_win[0] = c;
                    if (text_cnt < PAT_MAX)
                        text_cnt++;
                    // newest byte lines up with the last pattern byte
                    if (pat_len != 0 && text_cnt >= pat_len)
                    begin
                        same = 1'b1;
                        for (k = 0; k < pat_len; k++)
                            if (folded(txt_win[k]) != folded(pat_mem[pat_len - 1 - k]))
                                same = 1'b0;
                        if (same)
                            hit = 1'b1;
                    end
                end
                FUNC_END:
                begin
                    r.found = hit || (pat_len == 0);
                    r.too_long = overflow;
                    report_q.push_back(r);
                    clear();
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [7:0] d);
            report_t e;
            reports++;
            if (report_q.size() == 0)
            begin
                $display("%0t: unexpected report word, expected none, got %02h", $time, d);
                errors++;
                return;
            end
            e = report_q.pop_front();
            found_cnt += e.found;
            overflow_cnt += e.too_long;
            if (d[0] !== e.found)
            begin
                $display("%0t: found mismatch, expected %0d, got %b", $time, e.found, d[0]);
                errors++;
            end
            if (d[1] !== e.too_long)
            begin
                $display("%0t: pattern_too_long mismatch, expected %0d, got %b",
                         $time, e.too_long, d[1]);
                errors++;
            end
            if (d[7:2] !== 6'd0)
            begin
                $display("%0t: pad bits mismatch, expected 00, got %02h", $time, d[7:2]);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;     // [7:0] char_byte
    logic [1:0] s_tuser = '0;     // [1:0] func
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [0] found, [1] pattern_too_long, [7:2] zero
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [0:0] cfg_data = '0;    // [0] fold_en

    search_scoreboard sb;
    word_t plan_q[$];             // words waiting to be sent
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit hold_req = 1'b0;          // asks the receiver for one long hold-off
    int words_sent = 0;           // ignored kind not counted
    int quiet_cycles = 0;

    substring_search_case_fold_core #(
        .PAT_MAX(PAT_MAX)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Handshakes are sampled at the falling edge: inputs move only at rising edges,
    // so what is seen here is exactly what the next rising edge accepts.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_fold(cfg_data[0]);
            if (s_tvalid && s_tready)
                sb.note_word(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, no handshake for %0d cycles, %0d reports owed",
                         $time, quiet_cycles, sb.pending());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: random stalls at the current rate, plus one long hold-off on request
    // that keeps m_tready low while the sender keeps pushing words.
    initial
    begin : receiver
        int k;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
            end
            m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic queue_word(input logic [1:0] fn, input logic [7:0] ch);
        plan_q.push_back({fn, ch});
    endtask

    // Sends every queued word, with random idle cycles before each. Valid stays up
    // after the last word so the next plan can follow without a gap.
    task automatic send_plan();
        word_t w;
        logic took;
        while (plan_q.size() != 0)
        begin
            w = plan_q.pop_front();
            while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser <= w.fn;
            s_tdata <= w.ch;
            took = 1'b0;
            while (!took)
            begin
                @(negedge clk);
                took = s_tready;
                @(posedge clk);
            end
            if (w.fn != FUNC_UNUSED)
                words_sent++;
        end
    endtask

    // Drop valid, wait for all reports, then let the compare pipeline settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_case(input bit v);
        logic took;
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly a few letters of both cases so matches are common; some bytes at the
    // edges of the letter ranges, and some fully random ones.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 8'(($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + $urandom_range(2));
        if (r < 72)
        begin
            case ($urandom_range(4))
                0: return CHAR_UPPER_A - 8'd1;
                1: return CHAR_UPPER_Z;
                2: return CHAR_UPPER_Z + 8'd1;
                3: return CHAR_LOWER_A - 8'd1;
                default: return CHAR_LOWER_Z;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    // One search: pattern words, text words (often holding a copy of the pattern with
    // some letters case-swapped), an end word. A few runs are loose junk instead.
    task automatic plan_search();
        logic [7:0] pat [$];
        logic [7:0] txt [$];
        logic [7:0] c;
        int r, plen, kept, tlen, at, late, k;
        r = $urandom_range(99);
        if (r < 4)
        begin
            plen = $urandom_range(6, 1);
            for (k = 0; k < plen; k++)
                queue_word(2'($urandom_range(3)), 8'($urandom_range(255)));
            return;
        end
        if (r < 12)
            plen = 0;
        else if (r < 85)
            plen = $urandom_range(5, 1);
        else if (r < 94)
            plen = $urandom_range(PAT_MAX, 6);
        else
            plen = $urandom_range(PAT_MAX + 4, PAT_MAX + 1);   // overflows the store
        for (k = 0; k < plen; k++)
            pat.push_back(pick_char());
        kept = (plen > PAT_MAX) ? PAT_MAX : plen;
        tlen = $urandom_range(kept + 10, 0);
        for (k = 0; k < tlen; k++)
            txt.push_back(pick_char());
        if (kept != 0 && tlen >= kept && $urandom_range(99) < 60)
        begin
            at = $urandom_range(tlen - kept, 0);
            for (k = 0; k < kept; k++)
            begin
                c = pat[k];
                if ($urandom_range(9) < 3)
                begin
                    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
                        c = c + CASE_GAP;
                    else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
                        c = c - CASE_GAP;
                end
                txt[at + k] = c;
            end
        end
        // occasionally a pattern byte shows up after text has started
        late = ($urandom_range(99) < 6) ? $urandom_range(tlen, 0) : -1;
        foreach (pat[k])
            queue_word(FUNC_PATTERN, pat[k]);
        for (k = 0; k <= tlen; k++)
        begin
            if ($urandom_range(99) < 3)
                queue_word(FUNC_UNUSED, 8'($urandom_range(255)));
            if (k == late)
                queue_word(FUNC_PATTERN, pick_char());
            if (k < tlen)
                queue_word(FUNC_TEXT, txt[k]);
        end
        queue_word(FUNC_END, 8'($urandom_range(255)));
    endtask

    initial
    begin : stimulus
        int phase;
        int quota;
        int k;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_case(1'b0);

        // empty pattern always reports found
        queue_word(FUNC_END, 8'hFF);
        // zero bytes, but fewer text bytes than pattern bytes: no compare yet
        queue_word(FUNC_PATTERN, 8'h00);
        queue_word(FUNC_PATTERN, 8'h00);
        queue_word(FUNC_TEXT, 8'h00);
        queue_word(FUNC_END, 8'h00);
        // 'A' against 'a' with exact compare: no hit
        queue_word(FUNC_PATTERN, CHAR_UPPER_A);
        queue_word(FUNC_TEXT, CHAR_LOWER_A);
        send_plan();
        // folding turned on mid-search; ignored kind; pattern grows after text
        write_case(1'b1);
        queue_word(FUNC_UNUSED, 8'hFF);
        queue_word(FUNC_PATTERN, CHAR_UPPER_A + 8'd1);
        queue_word(FUNC_TEXT, CHAR_LOWER_A + 8'd1);
        queue_word(FUNC_END, 8'h80);
        // one pattern byte more than the store holds
        for (k = 0; k < PAT_MAX; k++)
            queue_word(FUNC_PATTERN, 8'hFF);
        queue_word(FUNC_PATTERN, 8'h80);
        queue_word(FUNC_END, 8'h01);
        send_plan();

        // random phases: no idling, sender idle 87%, receiver stall 87%, both 23%
        for (phase = 0; phase < 4; phase++)
        begin
            write_case((phase == 2) ? 1'($urandom_range(1)) : phase[0] ^ 1'b1);
            tx_idle_pct = (phase == 1) ? 87 : (phase == 3) ? 23 : 0;
            rx_stall_pct = (phase == 2) ? 87 : (phase == 3) ? 23 : 0;
            if (phase == 0)
                hold_req = 1'b1;
            quota = words_sent + RANDOM_WORDS / 4;
            while (words_sent < quota)
            begin
                plan_search();
                send_plan();
            end
        end
        // any junk run may leave a search open; close it so its report is checked
        queue_word(FUNC_END, 8'h00);
        send_plan();
        wait_idle();

        $display("%0d words accepted, %0d reports checked (%0d found, %0d overflowed)",
                 sb.words, sb.reports, sb.found_cnt, sb.overflow_cnt);
        $display("case folding written off %0d times, on %0d times; %0d mismatches",
                 sb.fold_writes[0], sb.fold_writes[1], sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
